/* rtl/mjl_pkg.sv */
package mjl_pkg;

    localparam int NUM_STATES_DEF = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int NOISE_W        = 53;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // 2*pi/3 in Q16.16, rounded to nearest
    localparam logic signed [34:0] TWO_PI_THIRD = 35'sd137258;

    localparam logic [2:0] REG_LEAVE_PROB = 3'd0;
    localparam logic [2:0] REG_CDF_S0     = 3'd1;
    localparam logic [2:0] REG_CDF_S1     = 3'd2;
    localparam logic [2:0] REG_CDF_S2     = 3'd3;
    localparam logic [2:0] REG_CDF_S3     = 3'd4;
    localparam logic [2:0] REG_REST_ANGLE = 3'd5;
    localparam logic [2:0] REG_HOLD_GAIN  = 3'd6;
    localparam logic [2:0] REG_NOISE_GAIN = 3'd7;

    localparam logic [16:0] HOLD_GAIN_RST = 17'd65536;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] start_angle;
        logic [1:0]         start_state;
        logic [15:0]        uniform_event;
        logic [15:0]        uniform_choice;
        logic signed [15:0] gaussian_sample;
    } t_in;

    typedef struct packed {
        logic signed [31:0] angle_out;
        logic [1:0]         state_out;
        logic signed [31:0] target_angle_out;
        logic signed [15:0] rotations_out;
    } t_out;

    typedef struct packed {
        logic [63:0]      leave_prob;
        logic [3:0][47:0] choice_cdf;
        logic [63:0]      rest_angle;
        logic [16:0]      hold_gain;
        logic [31:0]      noise_gain;
    } t_cfg;

    // classified step, after the state update
    typedef struct packed {
        logic               mode;
        logic signed [31:0] start_angle;
        logic [1:0]         state;
        logic signed [15:0] rotations;
        logic signed [15:0] gaussian;
    } t_cls;

    // word handed from the front end to the angle update
    typedef struct packed {
        logic                      mode;
        logic signed [31:0]        start_angle;
        logic [1:0]                state;
        logic signed [15:0]        rotations;
        logic signed [31:0]        target;
        logic signed [NOISE_W-1:0] noise;
    } t_work;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/mjl_in_if.sv */
interface mjl_in_if;
    logic         valid;
    logic         ready;
    mjl_pkg::t_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mjl_out_if.sv */
interface mjl_out_if;
    logic          valid;
    logic          ready;
    mjl_pkg::t_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mjl_front.sv */
module mjl_front #(
    parameter int NUM_STATES = mjl_pkg::NUM_STATES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mjl_in_if.sink         i_in,
    input  mjl_pkg::t_cfg  i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output mjl_pkg::t_work o_work
);
    import mjl_pkg::*;

    localparam logic [1:0] LAST = 2'(NUM_STATES - 1);
    localparam logic [1:0] LAST_CHOICE = 2'(NUM_STATES - 2);

    logic               r_state, n_dummy;
    logic [1:0]         r_cur, n_cur;
    logic signed [15:0] r_rot, n_rot;
    t_cls               r_cls, n_cls;
    logic               r_cls_valid;
    logic               accept;
    logic [1:0]         idx;
    logic [1:0]         nxt;
    logic [47:0]        cdf;

    assign i_in.ready = !r_cls_valid || !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = r_cls_valid && !i_full;
    assign n_dummy    = 1'b0;

    // jump decision and rotation count
    always_comb begin
        n_cur = r_cur;
        n_rot = r_rot;
        idx   = LAST_CHOICE;
        nxt   = r_cur;
        cdf   = i_cfg.choice_cdf[r_cur];
        if (i_in.payload.mode == MODE_START) begin
            n_cur = (i_in.payload.start_state > LAST) ? LAST : i_in.payload.start_state;
            n_rot = 16'sd0;
        end else if (i_in.payload.uniform_event < i_cfg.leave_prob[r_cur*16 +: 16]) begin
            // first threshold above the choice sample, lowest index wins
            for (int i = NUM_STATES - 2; i >= 0; i--) begin
                if (cdf[i*16 +: 16] > i_in.payload.uniform_choice) begin
                    idx = 2'(i);
                end
            end
            nxt   = (idx < r_cur) ? idx : idx + 2'd1;
            n_cur = nxt;
            if (r_cur == LAST && nxt == 2'd0) begin
                if (r_rot != 16'sh7fff) n_rot = r_rot + 16'sd1;
            end else if (r_cur == 2'd0 && nxt == LAST) begin
                if (r_rot != 16'sh8000) n_rot = r_rot - 16'sd1;
            end
        end
        n_cls.mode        = i_in.payload.mode;
        n_cls.start_angle = i_in.payload.start_angle;
        n_cls.state       = n_cur;
        n_cls.rotations   = n_rot;
        n_cls.gaussian    = i_in.payload.gaussian_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= 2'd0;
            r_rot       <= 16'sd0;
            r_cls_valid <= 1'b0;
            r_state     <= 1'b0;
        end else begin
            r_state <= n_dummy;
            if (accept) begin
                r_cur       <= n_cur;
                r_rot       <= n_rot;
                r_cls_valid <= 1'b1;
            end else if (o_push) begin
                r_cls_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    // target angle and noise term for the held word
    logic signed [34:0] turn;
    logic signed [39:0] target_sum;
    logic signed [48:0] nprod;

    always_comb begin
        turn       = 35'(r_cls.rotations) * TWO_PI_THIRD;
        target_sum = 40'($signed({1'b0, i_cfg.rest_angle[r_cls.state*16 +: 16], 3'b000}))
                   + 40'(turn);
        nprod      = $signed({1'b0, i_cfg.noise_gain}) * r_cls.gaussian;
        o_work.mode        = r_cls.mode;
        o_work.start_angle = r_cls.start_angle;
        o_work.state       = r_cls.state;
        o_work.rotations   = r_cls.rotations;
        o_work.target      = sat32(target_sum);
        o_work.noise       = {nprod, 4'b0000};
    end

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.payload.mode == MODE_START) |=> (r_rot == 16'sd0 && !r_state))
        else $error("rotation count not cleared by start");
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= LAST)
        else $error("chemical state out of range");
endmodule

/* rtl/mjl_queue.sv */
module mjl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mjl_pkg::t_work i_work,
    input  logic           i_pop,
    output mjl_pkg::t_work o_work,
    output logic           o_full,
    output logic           o_empty
);
    import mjl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_work            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("word popped from empty queue");
endmodule

/* rtl/mjl_back.sv */
module mjl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mjl_pkg::t_work i_work,
    input  logic           i_empty,
    input  logic [16:0]    i_hold_gain,
    output logic           o_pop,
    mjl_out_if.source      o_out
);
    import mjl_pkg::*;

    logic signed [31:0] r_angle, n_angle;
    logic               r_valid;
    t_out               r_out;

    logic signed [32:0] dev;
    logic signed [50:0] prod;
    logic signed [53:0] sum;
    logic signed [39:0] relax;

    assign o_pop         = !i_empty && (!r_valid || o_out.ready);
    assign o_out.valid   = r_valid;
    assign o_out.payload = r_out;

    // relax toward the target, round half up; a start word loads its start angle
    always_comb begin
        dev   = 33'(r_angle) - 33'(i_work.target);
        prod  = dev * $signed({1'b0, i_hold_gain});
        sum   = 54'(prod) + 54'(i_work.noise) + 54'sd32768;
        relax = 40'($signed(sum[53:16])) + 40'(i_work.target);
        if (i_work.mode == MODE_START) begin
            n_angle = i_work.start_angle;
        end else begin
            n_angle = sat32(relax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= 32'sd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_angle <= n_angle;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.angle_out        <= n_angle;
            r_out.state_out        <= i_work.state;
            r_out.target_angle_out <= i_work.target;
            r_out.rotations_out    <= i_work.rotations;
        end
    end

    a_out_matches_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out.angle_out == r_angle))
        else $error("result angle differs from held angle");
endmodule

/* rtl/markov_jump_langevin_angle_step_top.sv */
// Rotor step: Markov state jump plus linear Langevin angle relaxation.
// Throughput: one word per cycle while the result side is ready; the angle update
// (subtract, 33x18 multiply, add, round, saturate) is combinational and feeds
// back on itself through the angle register.
// Reset: state, rotation count and angle clear, the queue empties,
// registers take their defaults (hold gain 1.0, the rest zero).
module markov_jump_langevin_angle_step_top #(
    parameter int NUM_STATES = mjl_pkg::NUM_STATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mjl_in_if.sink      i_in,
    mjl_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import mjl_pkg::*;

    t_cfg  r_cfg;
    t_work front_work, head_work;
    logic  push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leave_prob <= '0;
            r_cfg.choice_cdf <= '0;
            r_cfg.rest_angle <= '0;
            r_cfg.hold_gain  <= HOLD_GAIN_RST;
            r_cfg.noise_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEAVE_PROB: r_cfg.leave_prob    <= i_cfg_data;
                REG_CDF_S0:     r_cfg.choice_cdf[0] <= i_cfg_data[47:0];
                REG_CDF_S1:     r_cfg.choice_cdf[1] <= i_cfg_data[47:0];
                REG_CDF_S2:     r_cfg.choice_cdf[2] <= i_cfg_data[47:0];
                REG_CDF_S3:     r_cfg.choice_cdf[3] <= i_cfg_data[47:0];
                REG_REST_ANGLE: r_cfg.rest_angle    <= i_cfg_data;
                REG_HOLD_GAIN:  r_cfg.hold_gain     <= i_cfg_data[16:0];
                REG_NOISE_GAIN: r_cfg.noise_gain    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    mjl_front #(.NUM_STATES(NUM_STATES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_work  (front_work)
    );

    mjl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (head_work),
        .o_full  (full),
        .o_empty (empty)
    );

    mjl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (head_work),
        .i_empty     (empty),
        .i_hold_gain (r_cfg.hold_gain),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule

/* test/markov_jump_langevin_angle_step_checker.sv */
module markov_jump_langevin_angle_step_checker
    import mjl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mjl_in_if           i_in,
    mjl_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_result_count
);

    localparam int NUM_ST = NUM_STATES_DEF;
    localparam longint ANGLE_HI = 64'sd2147483647;
    localparam longint ANGLE_LO = -64'sd2147483648;
    localparam int MAX_PRINTED = 100;

    // shadow registers
    logic [63:0] leave_tab;
    logic [47:0] cdf_tab [4];
    logic [63:0] rest_tab;
    logic [16:0] hold_k;
    logic [31:0] noise_k;

    // shadow rotor
    logic signed [31:0] rotor_angle;
    logic [1:0]         rotor_state;
    logic signed [15:0] rotor_turns;

    t_out predicted_rotor_q [$];
    int   fail_tally = 0;
    int   result_tally = 0;

    assign o_fail_count = fail_tally;

    task automatic report_mismatch(input string what);
        if (fail_tally < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, what);
        end
        fail_tally++;
    endtask

    function automatic logic [15:0] lane16(input logic [63:0] w, input int i);
        return w[16*i +: 16];
    endfunction

    function automatic longint clip32(input longint v);
        if (v > ANGLE_HI) return ANGLE_HI;
        if (v < ANGLE_LO) return ANGLE_LO;
        return v;
    endfunction

    // rest angle is Q3.13, widen to Q16.16 and add whole turns
    function automatic longint aim_angle(input logic [1:0] st, input longint turns);
        return clip32(longint'(lane16(rest_tab, st)) * 8 + turns * longint'(TWO_PI_THIRD));
    endfunction

    function automatic t_out rotor_advance(input t_in w);
        t_out       r;
        logic [1:0] from_st;
        logic [1:0] to_st;
        int         pick;
        longint     turns;
        longint     aim;
        longint     dev;
        longint     mix;
        if (w.mode == MODE_START) begin
            to_st = (int'(w.start_state) > NUM_ST - 1) ? 2'(NUM_ST - 1) : w.start_state;
            rotor_angle = w.start_angle;
            rotor_state = to_st;
            rotor_turns = '0;
            aim = aim_angle(to_st, 0);
        end else begin
            from_st = rotor_state;
            to_st = from_st;
            turns = rotor_turns;
            if (w.uniform_event < lane16(leave_tab, from_st)) begin
                pick = 0;
                while (pick < NUM_ST - 1 &&
                       lane16({16'h0000, cdf_tab[from_st]}, pick) <= w.uniform_choice) begin
                    pick++;
                end
                if (pick > NUM_ST - 2) pick = NUM_ST - 2;
                // skip the current state among the choices
                to_st = (pick < int'(from_st)) ? 2'(pick) : 2'(pick + 1);
                if (int'(from_st) == NUM_ST - 1 && to_st == 2'd0) begin
                    turns++;
                end else if (from_st == 2'd0 && int'(to_st) == NUM_ST - 1) begin
                    turns--;
                end
                if (turns > 32767) turns = 32767;
                if (turns < -32768) turns = -32768;
            end
            rotor_state = to_st;
            rotor_turns = 16'(turns);
            aim = aim_angle(to_st, turns);
            dev = longint'(rotor_angle) - aim;
            mix = dev * longint'(hold_k)
                + longint'(noise_k) * longint'(w.gaussian_sample) * 16;
            // round half up at 2^-16
            rotor_angle = 32'(clip32(aim + ((mix + 32768) >>> 16)));
        end
        r.angle_out        = rotor_angle;
        r.state_out        = rotor_state;
        r.target_angle_out = 32'(aim);
        r.rotations_out    = rotor_turns;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out seen;
        t_out want;
        if (!i_rst_n) begin
            leave_tab = '0;
            for (int s = 0; s < 4; s++) cdf_tab[s] = '0;
            rest_tab = '0;
            hold_k = HOLD_GAIN_RST;
            noise_k = '0;
            rotor_angle = '0;
            rotor_state = '0;
            rotor_turns = '0;
            predicted_rotor_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LEAVE_PROB: leave_tab  = i_cfg_data;
                    REG_CDF_S0:     cdf_tab[0] = i_cfg_data[47:0];
                    REG_CDF_S1:     cdf_tab[1] = i_cfg_data[47:0];
                    REG_CDF_S2:     cdf_tab[2] = i_cfg_data[47:0];
                    REG_CDF_S3:     cdf_tab[3] = i_cfg_data[47:0];
                    REG_REST_ANGLE: rest_tab   = i_cfg_data;
                    REG_HOLD_GAIN:  hold_k     = i_cfg_data[16:0];
                    REG_NOISE_GAIN: noise_k    = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                predicted_rotor_q.insert(predicted_rotor_q.size(),
                                         rotor_advance(i_in.payload));
            end
            if (i_out.valid && i_out.ready) begin
                seen = i_out.payload;
                result_tally++;
                if (predicted_rotor_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = predicted_rotor_q.pop_front();
                    if (seen.angle_out !== want.angle_out) begin
                        report_mismatch($sformatf("angle_out got %0d want %0d",
                                                  seen.angle_out, want.angle_out));
                    end
                    if (seen.state_out !== want.state_out) begin
                        report_mismatch($sformatf("state_out got %0d want %0d",
                                                  seen.state_out, want.state_out));
                    end
                    if (seen.target_angle_out !== want.target_angle_out) begin
                        report_mismatch($sformatf("target_angle_out got %0d want %0d",
                                                  seen.target_angle_out,
                                                  want.target_angle_out));
                    end
                    if (seen.rotations_out !== want.rotations_out) begin
                        report_mismatch($sformatf("rotations_out got %0d want %0d",
                                                  seen.rotations_out, want.rotations_out));
                    end
                end
            end
        end
        o_result_count <= result_tally;
    end

endmodule

/* test/markov_jump_langevin_angle_step_top_test.sv */
module markov_jump_langevin_angle_step_top_test;
    import mjl_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 294;
    localparam int SPIN_TURNS  = 8;
    localparam int IDLE_PCT    = 22;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    logic        calm;
    int          words_sent;
    int          fail_count;
    int          result_count;

    mjl_in_if  word_in ();
    mjl_out_if word_out ();

    markov_jump_langevin_angle_step_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (word_in),
        .o_out      (word_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    markov_jump_langevin_angle_step_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in           (word_in),
        .i_out          (word_out),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    always #4 clk = ~clk;

    // stall the result side at random, except during the calm stretch
    always @(posedge clk) begin
        word_out.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_word(input t_in w);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            word_in.valid <= 1'b0;
            @(posedge clk);
        end
        word_in.valid   <= 1'b1;
        word_in.payload <= w;
        @(posedge clk);
        while (!word_in.ready) @(posedge clk);
        words_sent++;
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic settle();
        word_in.valid <= 1'b0;
        while (result_count != words_sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(REG_LEAVE_PROB, c.leave_prob);
        write_reg(REG_CDF_S0, {16'h0000, c.choice_cdf[0]});
        write_reg(REG_CDF_S1, {16'h0000, c.choice_cdf[1]});
        write_reg(REG_CDF_S2, {16'h0000, c.choice_cdf[2]});
        write_reg(REG_CDF_S3, {16'h0000, c.choice_cdf[3]});
        write_reg(REG_REST_ANGLE, c.rest_angle);
        write_reg(REG_HOLD_GAIN, {47'd0, c.hold_gain});
        write_reg(REG_NOISE_GAIN, {32'd0, c.noise_gain});
        cfg_we <= 1'b0;
    endtask

    function automatic t_in make_word(input logic mode, input logic [31:0] angle,
                                      input logic [1:0] st, input logic [15:0] ue,
                                      input logic [15:0] uc, input logic [15:0] g);
        t_in w;
        w.mode            = mode;
        w.start_angle     = angle;
        w.start_state     = st;
        w.uniform_event   = ue;
        w.uniform_choice  = uc;
        w.gaussian_sample = g;
        return w;
    endfunction

    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        for (int s = 0; s < 4; s++) begin
            c.leave_prob[16*s +: 16] = pick_lane();
            c.rest_angle[16*s +: 16] = 16'($urandom);
            for (int i = 0; i < 3; i++) c.choice_cdf[s][16*i +: 16] = pick_lane();
        end
        case ($urandom_range(0, 4))
            0:       c.hold_gain = 17'd0;
            1:       c.hold_gain = HOLD_GAIN_RST;
            2:       c.hold_gain = 17'h1FFFF;
            3:       c.hold_gain = 17'($urandom_range(60000, 65536));
            default: c.hold_gain = 17'($urandom_range(0, 131071));
        endcase
        case ($urandom_range(0, 4))
            0:       c.noise_gain = 32'd0;
            1:       c.noise_gain = 32'hFFFF_FFFF;
            2:       c.noise_gain = $urandom;
            default: c.noise_gain = 32'($urandom_range(0, 262144));
        endcase
        return c;
    endfunction

    // tables that walk the states one way round on every step
    function automatic t_cfg spin_cfg(input bit forward);
        t_cfg c;
        c.leave_prob = 64'hFFFF_FFFF_FFFF_FFFF;
        c.rest_angle = {$urandom, $urandom};
        c.hold_gain  = HOLD_GAIN_RST;
        c.noise_gain = 32'($urandom_range(0, 65536));
        if (forward) begin
            c.choice_cdf[0] = 48'hFFFF_FFFF_FFFF;
            c.choice_cdf[1] = 48'hFFFF_FFFF_0000;
            c.choice_cdf[2] = 48'h0000_0000_0000;
            c.choice_cdf[3] = 48'hFFFF_FFFF_FFFF;
        end else begin
            c.choice_cdf[0] = 48'h0000_0000_0000;
            c.choice_cdf[1] = 48'hFFFF_FFFF_FFFF;
            c.choice_cdf[2] = 48'hFFFF_FFFF_0000;
            c.choice_cdf[3] = 48'h0000_0000_0000;
        end
        return c;
    endfunction

    function automatic t_in random_word(input int start_pct);
        t_in w;
        w.mode            = ($urandom_range(0, 99) < start_pct) ? MODE_START : MODE_STEP;
        w.start_angle     = pick_angle();
        w.start_state     = 2'($urandom);
        w.uniform_event   = pick_lane();
        w.uniform_choice  = pick_lane();
        w.gaussian_sample = ($urandom_range(0, 9) == 0) ? pick_lane() : 16'($urandom);
        return w;
    endfunction

    function automatic t_in spin_word();
        t_in w;
        w = random_word(0);
        w.uniform_event  = 16'($urandom_range(0, 16'hFFFE));
        w.uniform_choice = 16'($urandom_range(1, 16'hFFFE));
        return w;
    endfunction

    task automatic spin(input bit forward);
        settle();
        program_regs(spin_cfg(forward));
        calm <= 1'b1;
        send_word(make_word(MODE_START, $urandom, 2'd0, 16'h0000, 16'h0000, 16'h0000));
        // several full cycles in one direction
        for (int n = 0; n < 4 * SPIN_TURNS; n++) send_word(spin_word());
        calm <= 1'b0;
    endtask

    initial begin
        t_cfg regs;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = REG_LEAVE_PROB;
        cfg_data         = '0;
        calm             = 1'b0;
        words_sent       = 0;
        word_in.valid    = 1'b0;
        word_in.payload  = '0;
        word_out.ready   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset values: no jumps, angle held
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h7FFF));
        send_word(make_word(MODE_START, 32'h7FFF_FFFF, 2'd3, 16'hFFFF, 16'hFFFF, 16'h8000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'hFFFF, 16'h8000));
        settle();

        regs.leave_prob    = 64'hFFFF_FFFF_FFFF_FFFF;
        regs.choice_cdf[0] = 48'h0000_0000_0000;
        regs.choice_cdf[1] = 48'h9000_4000_1000;
        regs.choice_cdf[2] = 48'h8000_8000_8000;
        regs.choice_cdf[3] = 48'hFFFF_FFFF_FFFF;
        regs.rest_angle    = 64'h1234_8000_0000_FFFF;
        regs.hold_gain     = 17'h1FFFF;
        regs.noise_gain    = 32'hFFFF_FFFF;
        program_regs(regs);
        send_word(make_word(MODE_START, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h0000));
        // wrap backward, then forward across the last-to-first boundary
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h7FFF));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h8000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'hFFFF, 16'h0000, 16'h8000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'hFFFF, 16'h0001));
        // choice at the top of the table clamps to the last entry
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'hFFFF, 16'h0000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h8000, 16'hFFFF));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h1234, 16'h7FFF));
        send_word(make_word(MODE_START, 32'h8000_0000, 2'd2, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h7FFF, 16'h8000));
        send_word(make_word(MODE_START, 32'h7FFF_FFFF, 2'd1, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h0000));
        settle();

        // zero gains snap the angle onto the target
        regs.leave_prob = '0;
        regs.hold_gain  = 17'd0;
        regs.noise_gain = 32'd0;
        program_regs(regs);
        send_word(make_word(MODE_START, 32'h7FFF_FFFF, 2'd3, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h7FFF));
        send_word(make_word(MODE_START, 32'h8000_0000, 2'd0, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(MODE_STEP, 32'h0, 2'd0, 16'h0000, 16'h0000, 16'h8000));

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            program_regs(random_cfg());
            calm <= (ph == 3);
            send_word(make_word(MODE_START, pick_angle(), 2'($urandom), 16'h0000,
                                16'h0000, 16'h0000));
            for (int n = 1; n < PHASE_WORDS; n++) send_word(random_word(4));
        end
        calm <= 1'b0;

        spin(1'b1);
        spin(1'b0);

        settle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
